/* design/hfd_pkg.sv */
// ----------------------------------------------------------------------------
// hfd_pkg
// Shared widths, codes and the result record of the code-tree bit decoder.
// ----------------------------------------------------------------------------
package hfd_pkg;

  // Field widths fixed by the channel definitions
  localparam int unsigned IDX_W  = 9;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned KIND_W = 2;

  // Input opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CHAR = 1'b1;

  // Code characters
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ONE  = 8'h31;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

  // One result transaction
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  symbol;
    logic              last;
  } result_t;

endpackage

/* design/hfd_if.sv */
// ----------------------------------------------------------------------------
// hfd_in_if / hfd_out_if
// Valid/ready channels of the code-tree bit decoder.
// ----------------------------------------------------------------------------
interface hfd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [hfd_pkg::IDX_W-1:0]     node_index;
  logic [hfd_pkg::IDX_W-1:0]     left_child;
  logic [hfd_pkg::IDX_W-1:0]     right_child;
  logic [hfd_pkg::SYM_W-1:0]     node_symbol;
  logic [hfd_pkg::CHAR_W-1:0]    code_char;
  logic                          final_char;

  modport source (
    output valid, opcode, node_index, left_child, right_child, node_symbol,
           code_char, final_char,
    input  ready
  );
  modport sink (
    input  valid, opcode, node_index, left_child, right_child, node_symbol,
           code_char, final_char,
    output ready
  );
endinterface

interface hfd_out_if;
  logic                          valid;
  logic                          ready;
  logic [hfd_pkg::KIND_W-1:0]    result_kind;
  logic [hfd_pkg::SYM_W-1:0]     symbol_out;
  logic                          last_of_run;

  modport source (output valid, result_kind, symbol_out, last_of_run, input ready);
  modport sink   (input  valid, result_kind, symbol_out, last_of_run, output ready);
endinterface

/* design/hfd_ram.sv */
// ----------------------------------------------------------------------------
// hfd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hfd_ram #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/hfd_result_fifo.sv */
// ----------------------------------------------------------------------------
// hfd_result_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module hfd_result_fifo #(
  parameter int unsigned DEPTH = 4,   // power of two, at least 2
  localparam int unsigned PW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_a_i,
  input  hfd_pkg::result_t item_a_i,
  input  logic             push_b_i,
  input  hfd_pkg::result_t item_b_i,
  input  logic             pop_i,
  output logic             head_vld_o,
  output hfd_pkg::result_t head_o,
  output logic             room2_o
);

  hfd_pkg::result_t mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic [PW-1:0]    wr_b_ptr;
  logic             pop;

  assign pop      = pop_i && (count_q != '0);
  assign wr_b_ptr = push_a_i ? (wr_ptr_q + PW'(1)) : wr_ptr_q;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(push_a_i) + PW'(push_b_i);
    rd_ptr_d = rd_ptr_q + PW'(pop);
    count_d  = count_q + CW'(push_a_i) + CW'(push_b_i) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      mem_q[wr_ptr_q] <= item_a_i;
    end
    if (push_b_i) begin
      mem_q[wr_b_ptr] <= item_b_i;
    end
  end

  assign head_vld_o = (count_q != '0);
  assign head_o     = mem_q[rd_ptr_q];
  assign room2_o    = (count_q <= CW'(DEPTH - 2));

endmodule

/* design/huffman_tree_bit_decoder_top.sv */
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder_top
// Code-tree bit decoder: walks a node table held in RAM, one code character
// per transaction, and emits decoded symbols and string status.
//
//   Channel   Dir  Handshake          Payload
//   in_i      in   valid/ready        opcode, node fields, code_char, final
//   out_o     out  valid/ready        result_kind, symbol_out, last_of_run
//   cfg       in   cfg_we_i strobe    root_node (cfg_data_i)
//
// Load-node: one RAM write. Code character: only its child is read from RAM
// when its node sits in the entry register, else the node is read first
// (after reset, after a leaf or a root change); characters that fail in the
// idle state finish without a read. Reset clears walk, failure flag, root and
// entry register, not the node table. Input stalls while a character is in
// flight or while fewer than two of the four result queue slots are free.
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder_top #(
  parameter int unsigned NODE_COUNT  = 512,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hfd_pkg::IDX_W-1:0]  cfg_data_i,
  hfd_in_if.sink                     in_i,
  hfd_out_if.source                  out_o
);

  localparam int unsigned IW        = hfd_pkg::IDX_W;
  localparam int unsigned AW        = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned MW        = 2 * IW + SYMBOL_BITS;
  localparam int unsigned OUT_DEPTH = 4;
  localparam logic [31:0] NODE_LIM  = 32'(NODE_COUNT);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CUR   = 2'd1;
  localparam logic [1:0] ST_CHILD = 2'd2;

  // Index lies inside the table
  function automatic logic in_tab(input logic [IW-1:0] idx);
    return (32'(idx) < NODE_LIM);
  endfunction

  // Index names a real node
  function automatic logic node_ok(input logic [IW-1:0] idx);
    return (idx != '0) && (32'(idx) < NODE_LIM);
  endfunction

  // Table index to RAM address
  function automatic logic [AW-1:0] to_addr(input logic [IW-1:0] idx);
    logic [IW+AW-1:0] ext;
    ext = {{AW{1'b0}}, idx};
    return ext[AW-1:0];
  endfunction

  logic [1:0]             state_q, state_d;
  logic [IW-1:0]          walk_q, root_q, cur_q, cur_d, child_q, child_d;
  logic                   failed_q;
  logic                   go_right_q, go_right_d, final_q, final_d;

  // Node entry register with its tag
  logic                   cache_vld_q;
  logic [IW-1:0]          cache_idx_q, cache_left_q, cache_right_q;

  logic                   in_acc, in_load, in_char, room2;
  logic                   ram_we;
  logic [MW-1:0]          ram_wdata, ram_rdata;
  logic [IW-1:0]          raddr_idx;
  logic [IW-1:0]          rd_left, rd_right, child_rd, child_hit, cur_idx;
  logic [SYMBOL_BITS-1:0] rd_sym, sym_mem;
  logic [SYMBOL_BITS-1:0] in_sym_ext;
  logic                   ch_is0, ch_is1, hit;
  logic                   fill_vld;
  logic [IW-1:0]          fill_idx;

  // Finish of one character
  logic                   fin_vld, fin_fail, fin_sym_vld, fin_final;
  logic [IW-1:0]          fin_walk;
  logic                   at_root;
  logic [SYMBOL_BITS+hfd_pkg::SYM_W-1:0] sym_out_ext;
  logic [SYMBOL_BITS+hfd_pkg::SYM_W-1:0] sym_in_ext;
  hfd_pkg::result_t       item_a, item_b, head;
  logic                   push_a, push_b, head_vld;

  // Input handshake
  assign in_i.ready = (state_q == ST_IDLE) && room2;
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_load    = in_acc && (in_i.opcode == hfd_pkg::OP_LOAD);
  assign in_char    = in_acc && (in_i.opcode == hfd_pkg::OP_CHAR);

  // Table write from load-node transactions
  assign sym_in_ext = {{SYMBOL_BITS{1'b0}}, in_i.node_symbol};
  assign in_sym_ext = sym_in_ext[SYMBOL_BITS-1:0];
  assign ram_we     = in_load && in_tab(in_i.node_index);
  assign ram_wdata  = {in_i.left_child, in_i.right_child, in_sym_ext};

  hfd_ram #(
    .WIDTH (MW),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (to_addr(in_i.node_index)),
    .wdata_i (ram_wdata),
    .raddr_i (to_addr(raddr_idx)),
    .rdata_o (ram_rdata)
  );

  assign rd_left  = ram_rdata[MW-1 -: IW];
  assign rd_right = ram_rdata[MW-IW-1 -: IW];
  assign rd_sym   = ram_rdata[SYMBOL_BITS-1:0];
  assign child_rd = go_right_q ? rd_right : rd_left;

  // Current node and entry register lookup
  assign cur_idx   = (walk_q == '0) ? root_q : walk_q;
  assign ch_is0    = (in_i.code_char == hfd_pkg::CHAR_ZERO);
  assign ch_is1    = (in_i.code_char == hfd_pkg::CHAR_ONE);
  assign hit       = cache_vld_q && (cache_idx_q == cur_idx);
  assign child_hit = ch_is1 ? cache_right_q : cache_left_q;

  // Step the walk
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    child_d     = child_q;
    go_right_d  = go_right_q;
    final_d     = final_q;
    raddr_idx   = cur_idx;
    fill_vld    = 1'b0;
    fill_idx    = cur_q;
    fin_vld     = 1'b0;
    fin_fail    = failed_q;
    fin_sym_vld = 1'b0;
    fin_walk    = walk_q;
    fin_final   = final_q;
    unique case (state_q)
      ST_IDLE: begin
        fin_final = in_i.final_char;
        if (in_char) begin
          go_right_d = ch_is1;
          final_d    = in_i.final_char;
          cur_d      = cur_idx;
          if (failed_q || !node_ok(cur_idx) || !(ch_is0 || ch_is1)) begin
            fin_vld  = 1'b1;
            fin_fail = 1'b1;
          end else if (hit) begin
            if (!node_ok(child_hit)) begin
              fin_vld  = 1'b1;
              fin_fail = 1'b1;
            end else begin
              raddr_idx = child_hit;
              child_d   = child_hit;
              state_d   = ST_CHILD;
            end
          end else begin
            raddr_idx = cur_idx;
            state_d   = ST_CUR;
          end
        end
      end
      ST_CUR: begin
        fill_vld = 1'b1;
        fill_idx = cur_q;
        if (!node_ok(child_rd)) begin
          fin_vld  = 1'b1;
          fin_fail = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          raddr_idx = child_rd;
          child_d   = child_rd;
          state_d   = ST_CHILD;
        end
      end
      ST_CHILD: begin
        fill_vld = 1'b1;
        fill_idx = child_q;
        fin_vld  = 1'b1;
        if ((rd_left == '0) && (rd_right == '0)) begin
          fin_sym_vld = 1'b1;
          fin_walk    = '0;
        end else begin
          fin_walk = child_q;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      walk_q   <= '0;
      failed_q <= 1'b0;
      root_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        root_q <= cfg_data_i;
      end
      if (fin_vld) begin
        if (fin_final) begin
          walk_q   <= '0;
          failed_q <= 1'b0;
        end else begin
          walk_q   <= fin_walk;
          failed_q <= fin_fail;
        end
      end
    end
  end

  // Per-character working registers
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    child_q    <= child_d;
    go_right_q <= go_right_d;
    final_q    <= final_d;
  end

  // Entry register: fill from reads, forward table writes to the same node
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_vld_q <= 1'b0;
    end else if (fill_vld) begin
      cache_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_vld) begin
      cache_idx_q   <= fill_idx;
      cache_left_q  <= rd_left;
      cache_right_q <= rd_right;
    end else if (ram_we && (in_i.node_index == cache_idx_q)) begin
      cache_left_q  <= in_i.left_child;
      cache_right_q <= in_i.right_child;
    end
  end

  // Build result transactions; the leaf symbol always comes from the RAM read
  assign sym_mem     = rd_sym;
  assign sym_out_ext = {{hfd_pkg::SYM_W{1'b0}}, sym_mem};
  assign at_root     = (fin_walk == '0) || (fin_walk == root_q);

  always_comb begin
    item_b.kind   = (!fin_fail && at_root) ? hfd_pkg::KIND_ACCEPT : hfd_pkg::KIND_REJECT;
    item_b.symbol = '0;
    item_b.last   = 1'b1;
    if (fin_sym_vld) begin
      item_a.kind   = hfd_pkg::KIND_SYMBOL;
      item_a.symbol = sym_out_ext[hfd_pkg::SYM_W-1:0];
      item_a.last   = !fin_final;
    end else begin
      item_a = item_b;
    end
  end

  assign push_a = fin_vld && (fin_sym_vld || fin_final);
  assign push_b = fin_vld && fin_sym_vld && fin_final;

  hfd_result_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_result_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_a_i   (push_a),
    .item_a_i   (item_a),
    .push_b_i   (push_b),
    .item_b_i   (item_b),
    .pop_i      (out_o.ready),
    .head_vld_o (head_vld),
    .head_o     (head),
    .room2_o    (room2)
  );

  // Drive the output channel
  assign out_o.valid       = head_vld;
  assign out_o.result_kind = head.kind;
  assign out_o.symbol_out  = head.symbol;
  assign out_o.last_of_run = head.last;

endmodule
